### rtl/icf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the IMU complementary filter.
// No dependencies; every other file but tb/tb_channels.sv imports this package.
package icf_pkg;

    // Arctangent table, atan(2^-i) in degrees, Q24
    localparam int ATAN_LEN   = 24;
    localparam int TABLE_FRAC = 24;
    localparam int PRESCALE   = 14;
    localparam logic [31:0] ATAN_Q24 [ATAN_LEN] = '{
        32'd754974720, 32'd445687602, 32'd235489089, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

    // Nanoseconds per second and its half, used for rounding
    localparam logic [29:0] NS_PER_S = 30'd1000000000;
    localparam logic [29:0] HALF_NS  = 30'd500000000;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_NOISE_FLOOR = 3'd0,
        CFG_MAG_LOW     = 3'd1,
        CFG_MAG_HIGH    = 3'd2,
        CFG_MAX_STEP    = 3'd3,
        CFG_GYRO_WEIGHT = 3'd4
    } t_cfg_addr;

    // Reset values of the registers
    localparam logic [14:0] RST_NOISE_FLOOR = 15'd200;
    localparam logic [16:0] RST_MAG_LOW     = 17'd8192;
    localparam logic [16:0] RST_MAG_HIGH    = 17'd32768;
    localparam logic [23:0] RST_MAX_STEP    = 24'd5000000;
    localparam logic [16:0] RST_GYRO_WEIGHT = 17'd64225;
    localparam logic [16:0] WEIGHT_ONE      = 17'd65536;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_BLEND,
        ST_DONE
    } t_top_state;

    typedef enum logic [1:0] {
        IP_IDLE,
        IP_MUL,
        IP_DIV,
        IP_FIN
    } t_integ_phase;

    // Table entry rounded from Q24 to the angle fraction width
    function automatic logic [31:0] atan_entry(input logic [4:0] idx, input int shift);
        logic [31:0] t;
        t = ATAN_Q24[idx];
        if (shift == 0) begin
            return t;
        end
        return (t + (32'd1 << (shift - 1))) >> shift;
    endfunction

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

### rtl/icf_intf.sv
`timescale 1ns / 1ps
// Handshake channels of the filter: sample input, result output, register writes.
// Depends on icf_pkg for the configuration port widths.
interface icf_sample_if;
    logic               valid;
    logic               ready;
    logic [23:0]        step_us;
    logic signed [23:0] rate_x;
    logic signed [23:0] rate_y;
    logic signed [23:0] rate_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    modport source (output valid, step_us, rate_x, rate_y, rate_z,
                    accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, step_us, rate_x, rate_y, rate_z,
                    accel_x, accel_y, accel_z, output ready);
endinterface

interface icf_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pitch_deg;
    logic signed [31:0] roll_deg;
    logic signed [31:0] yaw_deg;
    logic               accel_applied;
    logic               sample_skipped;
    modport source (output valid, pitch_deg, roll_deg, yaw_deg, accel_applied,
                    sample_skipped, input ready);
    modport sink   (input valid, pitch_deg, roll_deg, yaw_deg, accel_applied,
                    sample_skipped, output ready);
endinterface

interface icf_cfg_if;
    import icf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

### rtl/icf_integ.sv
`timescale 1ns / 1ps
// Gyro integrator: bit-serial |rate| * step, bit-serial division by 10^9 with
// rounding, then saturated add to the angle. Depends on icf_pkg.
module icf_integ import icf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_angle,
    input  logic signed [23:0] i_rate,
    input  logic [23:0]        i_step,
    output logic               o_done,
    output logic signed [31:0] o_angle
);
    localparam int PW = 48;
    localparam int NW = PW + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    t_integ_phase       r_phase, n_phase;
    logic [CW-1:0]      r_cnt;
    logic [PW-1:0]      r_mcand;
    logic [23:0]        r_mplier;
    logic [PW-1:0]      r_acc;
    logic [NW-1:0]      r_num;
    logic [29:0]        r_rem;
    logic [32:0]        r_quo;
    logic               r_ovf;
    logic               r_neg;
    logic signed [31:0] r_angle;
    logic               r_done;
    logic signed [31:0] r_out;

    logic [23:0]        w_abs;
    logic [PW-1:0]      w_acc_next;
    logic [30:0]        w_trial;
    logic               w_ge;
    logic [30:0]        w_sub;
    logic signed [34:0] w_sum;

    assign w_abs      = i_rate[23] ? 24'(-i_rate) : 24'(i_rate);
    assign w_acc_next = r_acc + (r_mplier[0] ? r_mcand : '0);
    assign w_trial    = {r_rem, r_num[NW-1]};
    assign w_ge       = w_trial >= {1'b0, NS_PER_S};
    assign w_sub      = w_trial - {1'b0, NS_PER_S};
    assign w_sum      = 35'(r_angle) + (r_neg ? -$signed({2'b00, r_quo})
                                              : $signed({2'b00, r_quo}));

    // Advance phases
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            IP_IDLE: if (i_start) n_phase = IP_MUL;
            IP_MUL:  if (r_cnt == CW'(23)) n_phase = IP_DIV;
            IP_DIV:  if (r_cnt == CW'(NW - 1)) n_phase = IP_FIN;
            IP_FIN:  n_phase = IP_IDLE;
            default: n_phase = IP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= IP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == IP_FIN);
        end
    end

    // Shift-add multiply, restoring divide, saturate
    always_ff @(posedge i_clk) begin
        case (r_phase)
            IP_IDLE: begin
                r_mcand  <= {24'd0, w_abs};
                r_mplier <= i_step;
                r_acc    <= '0;
                r_cnt    <= '0;
                r_neg    <= i_rate[23];
                r_angle  <= i_angle;
            end
            IP_MUL: begin
                r_acc    <= w_acc_next;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == CW'(23)) begin
                    r_num <= (NW'(w_acc_next) << FRAC_BITS) + NW'(HALF_NS);
                    r_rem <= '0;
                    r_quo <= '0;
                    r_ovf <= 1'b0;
                    r_cnt <= '0;
                end
            end
            IP_DIV: begin
                r_num <= r_num << 1;
                r_rem <= w_ge ? w_sub[29:0] : w_trial[29:0];
                r_quo <= {r_quo[31:0], w_ge};
                r_ovf <= r_ovf | r_quo[32];
                r_cnt <= r_cnt + 1'b1;
            end
            IP_FIN: begin
                if (r_ovf) begin
                    r_out <= r_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
                end else begin
                    r_out <= sat32(64'(w_sum));
                end
            end
            default: ;
        endcase
    end

    assign o_done  = r_done;
    assign o_angle = r_out;

endmodule

### rtl/icf_cordic.sv
`timescale 1ns / 1ps
// Vectoring CORDIC for atan2 in degrees, one micro-rotation per cycle.
// Depends on icf_pkg for the arctangent table and saturation.
module icf_cordic import icf_pkg::*; #(
    parameter int STEPS     = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_num,
    input  logic signed [15:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_angle
);
    localparam int NSTEP = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;
    localparam int IW    = $clog2(NSTEP);
    localparam int SHIFT = TABLE_FRAC - FRAC_BITS;
    localparam int XW    = 34;
    localparam int AW    = 34;

    logic                 r_busy;
    logic [IW-1:0]        r_i;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [AW-1:0] r_ang;
    logic                 r_done;
    logic signed [31:0]   r_out;

    logic signed [XW-1:0] w_den, w_num, w_xs, w_ys;
    logic signed [AW-1:0] w_half, w_entry, w_ang_next;

    assign w_den      = {{(XW-16){i_den[15]}}, i_den};
    assign w_num      = {{(XW-16){i_num[15]}}, i_num};
    assign w_half     = AW'(180) <<< FRAC_BITS;
    assign w_xs       = r_x >>> r_i;
    assign w_ys       = r_y >>> r_i;
    assign w_entry    = {2'b00, atan_entry(5'(r_i), SHIFT)};
    assign w_ang_next = (r_y > 0) ? r_ang + w_entry : r_ang - w_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_start) begin
                if (i_num == 16'sd0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && r_i == IW'(NSTEP - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Fold the left half-plane, then rotate toward the x axis
    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            r_i <= '0;
            if (i_start) begin
                if (i_num == 16'sd0) begin
                    r_out <= i_den[15] ? sat32(64'(w_half)) : 32'sd0;
                end else if (i_den[15]) begin
                    r_x   <= (-w_den) <<< PRESCALE;
                    r_y   <= (-w_num) <<< PRESCALE;
                    r_ang <= i_num[15] ? -w_half : w_half;
                end else begin
                    r_x   <= w_den <<< PRESCALE;
                    r_y   <= w_num <<< PRESCALE;
                    r_ang <= '0;
                end
            end
        end else begin
            if (r_y > 0) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
            end
            r_ang <= w_ang_next;
            r_i   <= r_i + 1'b1;
            if (r_i == IW'(NSTEP - 1)) begin
                r_out <= sat32(64'(w_ang_next));
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_out;

endmodule

### rtl/icf_blend.sv
`timescale 1ns / 1ps
// Weighted blend of gyro and accel angle: gyro product, accel product, round and clamp.
// Depends on icf_pkg for the weight limit and saturation.
module icf_blend import icf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_angle,
    input  logic signed [31:0] i_acc,
    input  logic [16:0]        i_weight,
    output logic               o_done,
    output logic signed [31:0] o_angle
);
    logic [1:0]         r_step;
    logic               r_done;
    logic signed [49:0] r_prod;
    logic signed [51:0] r_sum;
    logic signed [31:0] r_out;

    logic [16:0]        w_w;
    logic signed [17:0] w_ws, w_was;
    logic signed [49:0] w_p1, w_p2;
    logic signed [51:0] w_round;

    assign w_w     = (i_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_weight;
    assign w_ws    = {1'b0, w_w};
    assign w_was   = {1'b0, WEIGHT_ONE - w_w};
    assign w_p1    = i_angle * w_ws;
    assign w_p2    = i_acc * w_was;
    assign w_round = (r_sum + 52'sd32768) >>> 16;

    // Step through gyro product, accel product, round and clamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_step == 2'd0) begin
                if (i_start) r_step <= 2'd1;
            end else if (r_step == 2'd3) begin
                r_step <= 2'd0;
                r_done <= 1'b1;
            end else begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_step)
            2'd1:    r_prod <= w_p1;
            2'd2:    r_sum  <= 52'(r_prod) + 52'(w_p2);
            2'd3:    r_out  <= sat32(64'(w_round));
            default: ;
        endcase
    end

    assign o_done  = r_done;
    assign o_angle = r_out;

endmodule

### rtl/imu_complementary_filter_top.sv
`timescale 1ns / 1ps
// Top level of the IMU complementary filter: registers, sequencer, units.
// Depends on icf_pkg, the channel interfaces, icf_integ, icf_cordic, icf_blend.
//
//  channel    dir  payload                                            accepted when
//  i_sample   in   step_us, rate_x/y/z, accel_x/y/z                   valid & ready
//  o_result   out  pitch_deg, roll_deg, yaw_deg, accel_applied,
//                  sample_skipped                                     valid & ready
//  i_cfg      in   addr, data (register write)                        valid & ready
//
// One request at a time: the bit-serial multiply and divide of the gyro
// integrators set the pace, the CORDIC runs alongside and blending follows.
// A skipped sample bypasses the units.
// Reset (synchronous, active low) zeroes the angles and loads register defaults.
// The result sits in an output register; a stalled output delays only the
// hand-off of the next result.
module imu_complementary_filter_top import icf_pkg::*; #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    icf_sample_if.sink   i_sample,
    icf_result_if.source o_result,
    icf_cfg_if.sink      i_cfg
);
    // Configuration registers
    logic [14:0] r_noise_floor;
    logic [16:0] r_mag_low, r_mag_high, r_gyro_weight;
    logic [23:0] r_max_step;

    t_top_state r_state, n_state;
    logic signed [31:0] r_pitch, r_roll, r_yaw;
    logic               r_skip, r_apply;
    logic [4:0]         r_flags;
    logic [1:0]         r_bflags;
    logic               r_out_valid;
    logic signed [31:0] r_out_pitch, r_out_roll, r_out_yaw;
    logic               r_out_apply, r_out_skip;

    logic        w_accept, w_start, w_skip, w_apply, w_blend_start, w_load;
    logic [16:0] w_mx, w_my, w_mz;
    logic [17:0] w_msum;
    logic signed [15:0] w_ax, w_ay;
    logic [4:0]  w_dones;
    logic [1:0]  w_bdones;
    logic signed [31:0] w_ip, w_ir, w_iy, w_cp, w_cr, w_bp, w_br;
    logic signed [31:0] w_new_pitch, w_new_roll;

    // Register writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_floor <= RST_NOISE_FLOOR;
            r_mag_low     <= RST_MAG_LOW;
            r_mag_high    <= RST_MAG_HIGH;
            r_max_step    <= RST_MAX_STEP;
            r_gyro_weight <= RST_GYRO_WEIGHT;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                CFG_NOISE_FLOOR: r_noise_floor <= i_cfg.data[14:0];
                CFG_MAG_LOW:     r_mag_low     <= i_cfg.data[16:0];
                CFG_MAG_HIGH:    r_mag_high    <= i_cfg.data[16:0];
                CFG_MAX_STEP:    r_max_step    <= i_cfg.data[23:0];
                CFG_GYRO_WEIGHT: r_gyro_weight <= i_cfg.data[16:0];
                default: ;
            endcase
        end
    end

    // Qualify the incoming sample
    assign i_sample.ready = (r_state == ST_IDLE);
    assign w_accept = i_sample.valid && i_sample.ready;
    assign w_mx   = i_sample.accel_x[15] ? 17'(-{1'b1, i_sample.accel_x})
                                         : {1'b0, i_sample.accel_x};
    assign w_my   = i_sample.accel_y[15] ? 17'(-{1'b1, i_sample.accel_y})
                                         : {1'b0, i_sample.accel_y};
    assign w_mz   = i_sample.accel_z[15] ? 17'(-{1'b1, i_sample.accel_z})
                                         : {1'b0, i_sample.accel_z};
    assign w_msum = 18'(w_mx) + 18'(w_my) + 18'(w_mz);
    assign w_skip = i_sample.step_us > r_max_step;
    assign w_apply = !w_skip && (w_msum > 18'(r_mag_low)) && (w_msum < 18'(r_mag_high));
    assign w_ax   = (w_mx < 17'(r_noise_floor)) ? 16'sd0 : i_sample.accel_x;
    assign w_ay   = (w_my < 17'(r_noise_floor)) ? 16'sd0 : i_sample.accel_y;
    assign w_start = w_accept && !w_skip;

    icf_integ #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_integ_pitch (
        .i_clk, .i_rst_n, .i_start(w_start), .i_angle(r_pitch),
        .i_rate(i_sample.rate_x), .i_step(i_sample.step_us),
        .o_done(w_dones[0]), .o_angle(w_ip));
    icf_integ #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_integ_roll (
        .i_clk, .i_rst_n, .i_start(w_start), .i_angle(r_roll),
        .i_rate(i_sample.rate_y), .i_step(i_sample.step_us),
        .o_done(w_dones[1]), .o_angle(w_ir));
    icf_integ #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_integ_yaw (
        .i_clk, .i_rst_n, .i_start(w_start), .i_angle(r_yaw),
        .i_rate(i_sample.rate_z), .i_step(i_sample.step_us),
        .o_done(w_dones[2]), .o_angle(w_iy));
    icf_cordic #(.STEPS(CORDIC_STEPS), .FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic_pitch (
        .i_clk, .i_rst_n, .i_start(w_start), .i_num(w_ay),
        .i_den(i_sample.accel_z), .o_done(w_dones[3]), .o_angle(w_cp));
    icf_cordic #(.STEPS(CORDIC_STEPS), .FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic_roll (
        .i_clk, .i_rst_n, .i_start(w_start), .i_num(w_ax),
        .i_den(i_sample.accel_z), .o_done(w_dones[4]), .o_angle(w_cr));
    icf_blend u_blend_pitch (
        .i_clk, .i_rst_n, .i_start(w_blend_start), .i_angle(w_ip), .i_acc(w_cp),
        .i_weight(r_gyro_weight), .o_done(w_bdones[0]), .o_angle(w_bp));
    icf_blend u_blend_roll (
        .i_clk, .i_rst_n, .i_start(w_blend_start), .i_angle(w_ir), .i_acc(w_cr),
        .i_weight(r_gyro_weight), .o_done(w_bdones[1]), .o_angle(w_br));

    assign w_new_pitch = r_skip ? r_pitch : (r_apply ? w_bp : w_ip);
    assign w_new_roll  = r_skip ? r_roll  : (r_apply ? w_br : w_ir);

    // Next state and unit starts
    always_comb begin
        n_state       = r_state;
        w_blend_start = 1'b0;
        w_load        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = w_skip ? ST_DONE : ST_RUN;
            end
            ST_RUN: begin
                if (&r_flags) begin
                    n_state       = r_apply ? ST_BLEND : ST_DONE;
                    w_blend_start = r_apply;
                end
            end
            ST_BLEND: begin
                if (&r_bflags) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pitch     <= '0;
            r_roll      <= '0;
            r_yaw       <= '0;
            r_flags     <= '0;
            r_bflags    <= '0;
            r_out_valid <= 1'b0;
            r_skip      <= 1'b0;
            r_apply     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_skip   <= w_skip;
                r_apply  <= w_apply;
                r_flags  <= '0;
                r_bflags <= '0;
            end else begin
                r_flags  <= r_flags | w_dones;
                r_bflags <= r_bflags | w_bdones;
            end
            // Drop the result once taken, then commit a new one
            if (o_result.ready) r_out_valid <= 1'b0;
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_pitch     <= w_new_pitch;
                r_roll      <= w_new_roll;
                if (!r_skip) r_yaw <= w_iy;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_pitch <= w_new_pitch;
            r_out_roll  <= w_new_roll;
            r_out_yaw   <= r_skip ? r_yaw : w_iy;
            r_out_apply <= r_apply && !r_skip;
            r_out_skip  <= r_skip;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.pitch_deg      = r_out_pitch;
    assign o_result.roll_deg       = r_out_roll;
    assign o_result.yaw_deg        = r_out_yaw;
    assign o_result.accel_applied  = r_out_apply;
    assign o_result.sample_skipped = r_out_skip;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != ST_IDLE)
        else $error("sequencer idle right after a request");
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_apply && r_out_skip))
        else $error("skipped sample reported as blended");
    a_skip_holds_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_skip) |=> (r_pitch == $past(r_pitch) && r_yaw == $past(r_yaw)))
        else $error("skipped sample changed the angles");
    a_blend_only_applied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_blend_start |-> (r_apply && !r_skip && r_state == ST_RUN))
        else $error("blend started without accel correction");

endmodule

### tb/tb_pkg.sv
`timescale 1ns / 1ps
// Sample and attitude types used by the filter testbench.
// Imports icf_pkg but uses none of its names.
package tb_pkg;
    import icf_pkg::*;

    typedef struct packed {
        logic [23:0]        step_us;
        logic signed [23:0] rate_x;
        logic signed [23:0] rate_y;
        logic signed [23:0] rate_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } imu_sample_t;

    typedef struct packed {
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
        logic signed [31:0] yaw;
        logic               applied;
        logic               skipped;
    } attitude_t;
endpackage

### tb/tb_channels.sv
`timescale 1ns / 1ps
// Testbench-side notes on the channel interfaces.
// The interfaces themselves come from rtl/icf_intf.sv; this file holds no logic.
package tb_channels_pkg;
    localparam int STALL_MAX = 13;
endpackage

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench of the IMU complementary filter: directed and random samples,
// register phases, in-bench attitude predictor and field-by-field result check.
// Depends on icf_pkg, tb_pkg, tb_channels_pkg, icf_intf and the filter RTL.
module tb;
    import icf_pkg::*;
    import tb_pkg::*;
    import tb_channels_pkg::*;

    localparam int CSTEPS = 16;
    localparam int FRAC   = 16;
    localparam int QUIET  = 400;
    localparam int HOLD_CYCLES = 3000;

    logic i_clk;
    logic i_rst_n;

    icf_sample_if smp ();
    icf_result_if res ();
    icf_cfg_if    cfg ();

    imu_complementary_filter_top #(.CORDIC_STEPS(CSTEPS), .ANGLE_FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_sample(smp.sink), .o_result(res.source), .i_cfg(cfg.sink)
    );

    // Predictor state and register copies
    logic [14:0]        noise_floor_r;
    logic [16:0]        mag_low_r;
    logic [16:0]        mag_high_r;
    logic [23:0]        max_step_r;
    logic [16:0]        weight_r;
    logic signed [31:0] pitch_q, roll_q, yaw_q;

    imu_sample_t sample_queue[$];
    attitude_t   expected_att[$];
    int          error_count;
    int          sent_count;
    bit          calm;          // no idling on either side
    bit          hold_sender;   // sender pauses
    bit          hold_rx;       // receiver long hold-off active
    int          tx_gap, rx_gap;

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint sat_q(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    // Rate times step, rounded half away from zero, added with saturation
    function automatic longint add_rate(input longint ang, input longint rate,
                                        input longint step);
        longint unsigned mag, q, r, inc;
        mag = longint'(rate < 0 ? -rate : rate) * step;
        q = mag / 64'd1000000000;
        r = mag % 64'd1000000000;
        inc = (q << FRAC) + ((r << FRAC) + 64'd500000000) / 64'd1000000000;
        return sat_q(ang + (rate < 0 ? -longint'(inc) : longint'(inc)));
    endfunction

    function automatic longint tilt_deg(input longint num, input longint den);
        longint half, base, ang, x, y, xs, ys, t;
        int n;
        half = longint'(180) << FRAC;
        base = 0;
        ang = 0;
        if (num == 0) return den < 0 ? half : 0;
        x = den;
        y = num;
        if (x < 0) begin
            base = (y >= 0) ? half : -half;
            x = -x;
            y = -y;
        end
        x = x <<< 14;
        y = y <<< 14;
        n = CSTEPS < 24 ? CSTEPS : 24;
        for (int i = 0; i < n; i++) begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            t = longint'(ATAN_Q24[i]);
            if (24 - FRAC > 0) t = (t + (longint'(1) << (24 - FRAC - 1))) >>> (24 - FRAC);
            if (y > 0) begin
                x += ys; y -= xs; ang += t;
            end else begin
                x -= ys; y += xs; ang -= t;
            end
        end
        return sat_q(base + ang);
    endfunction

    function automatic longint mix(input longint ang, input longint acc, input longint w);
        return sat_q(shr_floor(ang * w + acc * (65536 - w) + 32768, 16));
    endfunction

    // Advance the predicted attitude by one sample
    function automatic attitude_t predict_attitude(input imu_sample_t s);
        attitude_t a;
        longint ax, ay, az, mx, my, mz, sum, w;
        ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
        a.applied = 1'b0;
        a.skipped = s.step_us > max_step_r;
        if (!a.skipped) begin
            mx = ax < 0 ? -ax : ax;
            my = ay < 0 ? -ay : ay;
            mz = az < 0 ? -az : az;
            sum = mx + my + mz;
            pitch_q = add_rate(pitch_q, s.rate_x, s.step_us);
            roll_q  = add_rate(roll_q, s.rate_y, s.step_us);
            yaw_q   = add_rate(yaw_q, s.rate_z, s.step_us);
            if (mx < noise_floor_r) ax = 0;
            if (my < noise_floor_r) ay = 0;
            if (sum > mag_low_r && sum < mag_high_r) begin
                w = weight_r > 65536 ? 65536 : weight_r;
                pitch_q = mix(pitch_q, tilt_deg(ay, az), w);
                roll_q  = mix(roll_q, tilt_deg(ax, az), w);
                a.applied = 1'b1;
            end
        end
        a.pitch = pitch_q;
        a.roll  = roll_q;
        a.yaw   = yaw_q;
        return a;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Driver: offer queued requests, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (smp.valid && smp.ready) begin
                expected_att.push_back(predict_attitude(sample_queue.pop_front()));
                sent_count++;
            end
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                smp.valid <= 1'b0;
            end else if (sample_queue.size() > 0 && !hold_sender
                         && (!(smp.valid && smp.ready) || sample_queue.size() > 0)) begin
                if (!calm && $urandom_range(0, 9) == 0 && !(smp.valid && !smp.ready)) begin
                    tx_gap <= $urandom_range(1, STALL_MAX);
                    smp.valid <= 1'b0;
                end else begin
                    smp.valid   <= 1'b1;
                    smp.step_us <= sample_queue[0].step_us;
                    smp.rate_x  <= sample_queue[0].rate_x;
                    smp.rate_y  <= sample_queue[0].rate_y;
                    smp.rate_z  <= sample_queue[0].rate_z;
                    smp.accel_x <= sample_queue[0].accel_x;
                    smp.accel_y <= sample_queue[0].accel_y;
                    smp.accel_z <= sample_queue[0].accel_z;
                end
            end else if (!(smp.valid && !smp.ready)) begin
                smp.valid <= 1'b0;
            end
        end
    end

    // Monitor: apply back-pressure and compare each result
    always @(posedge i_clk) begin
        attitude_t e;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (res.valid && res.ready) begin
                if (expected_att.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    e = expected_att.pop_front();
                    if (res.pitch_deg !== e.pitch) report_mismatch("pitch", res.pitch_deg, e.pitch);
                    if (res.roll_deg !== e.roll) report_mismatch("roll", res.roll_deg, e.roll);
                    if (res.yaw_deg !== e.yaw) report_mismatch("yaw", res.yaw_deg, e.yaw);
                    if (res.accel_applied !== e.applied)
                        report_mismatch("accel_applied", res.accel_applied, e.applied);
                    if (res.sample_skipped !== e.skipped)
                        report_mismatch("sample_skipped", res.sample_skipped, e.skipped);
                end
            end
            if (hold_rx) begin
                res.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                res.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                rx_gap <= $urandom_range(1, STALL_MAX);
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input t_cfg_addr idx, input logic [23:0] val);
        @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.addr  <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_NOISE_FLOOR: noise_floor_r = val[14:0];
            CFG_MAG_LOW:     mag_low_r = val[16:0];
            CFG_MAG_HIGH:    mag_high_r = val[16:0];
            CFG_MAX_STEP:    max_step_r = val;
            CFG_GYRO_WEIGHT: weight_r = val[16:0];
            default: ;
        endcase
    endtask

    // Wait until every expected result arrived, then let the block settle
    task automatic drain();
        while (sample_queue.size() > 0 || smp.valid || expected_att.size() > 0)
            @(posedge i_clk);
        repeat (QUIET) @(posedge i_clk);
    endtask

    task automatic push_sample(input logic [23:0] st, input int rx, input int ry,
                               input int rz, input int ax, input int ay, input int az);
        imu_sample_t s;
        s.step_us = st; s.rate_x = 24'(rx); s.rate_y = 24'(ry); s.rate_z = 24'(rz);
        s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
        sample_queue.push_back(s);
    endtask

    // Random sample, mostly in the correction window with realistic rates
    task automatic push_random();
        imu_sample_t s;
        s.step_us = 24'($urandom);
        s.rate_x  = 24'($urandom);
        s.rate_y  = 24'($urandom);
        s.rate_z  = 24'($urandom);
        s.accel_x = 16'($urandom);
        s.accel_y = 16'($urandom);
        s.accel_z = 16'($urandom);
        case ($urandom_range(0, 9))
            0, 1: ;
            2: s.step_us = 24'($urandom_range(0, 2000));
            default: begin
                s.step_us = 24'($urandom_range(0, 20000));
                s.rate_x = 24'($urandom_range(0, 400000) - 200000);
                s.rate_y = 24'($urandom_range(0, 400000) - 200000);
                s.accel_x = 16'($urandom_range(0, 12000) - 6000);
                s.accel_y = 16'($urandom_range(0, 12000) - 6000);
                s.accel_z = 16'($urandom_range(0, 12000) - 6000);
            end
        endcase
        sample_queue.push_back(s);
    endtask

    // Stimulus
    initial begin
        i_rst_n = 1'b0;
        cfg.valid = 1'b0; cfg.addr = '0; cfg.data = '0;
        smp.valid = 1'b0; smp.step_us = '0; smp.rate_x = '0; smp.rate_y = '0;
        smp.rate_z = '0; smp.accel_x = '0; smp.accel_y = '0; smp.accel_z = '0;
        res.ready = 1'b0;
        noise_floor_r = RST_NOISE_FLOOR; mag_low_r = RST_MAG_LOW;
        mag_high_r = RST_MAG_HIGH; max_step_r = RST_MAX_STEP; weight_r = RST_GYRO_WEIGHT;
        pitch_q = 0; roll_q = 0; yaw_q = 0;
        error_count = 0; sent_count = 0;
        calm = 1'b0; hold_sender = 1'b0; hold_rx = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // Directed: field extremes, skip, zero numerator, both zero, most negative accel
        push_sample(0, 0, 0, 0, 0, 0, 0);
        push_sample(1000, 1000, -1000, 500, 0, 0, 16000);
        push_sample(1000, 0, 0, 0, 0, 0, -16000);
        push_sample(1000, 0, 0, 0, 4000, -4000, -10000);
        push_sample(1000, 0, 0, 0, -32768, 100, 0);
        push_sample(5000000, 8388607, -8388608, 8388607, 100, -100, 10000);
        push_sample(5000001, 1, 1, 1, 0, 0, 10000);
        push_sample(24'hFFFFFF, -8388608, 8388607, -8388608, -32768, -32768, -32768);
        push_sample(5000000, 8388607, 8388607, 8388607, 32767, 32767, 32767);
        push_sample(5000000, 8388607, 8388607, 8388607, 3000, 3000, 3000);
        push_sample(5000000, -8388608, -8388608, -8388608, 199, 200, 8000);
        push_sample(3, 333, -333, 1, 10000, 0, 0);
        push_sample(3, 1, 1, 1, -10000, 0, 0);
        drain();

        // Register phases: extremes then mid settings
        write_reg(CFG_GYRO_WEIGHT, 24'd65536);
        write_reg(CFG_NOISE_FLOOR, 24'd0);
        write_reg(CFG_MAG_LOW, 24'd0);
        write_reg(CFG_MAG_HIGH, 24'd98304);
        write_reg(CFG_MAX_STEP, 24'hFFFFFF);
        for (int i = 0; i < 300; i++) push_random();
        drain();
        write_reg(CFG_GYRO_WEIGHT, 24'd0);
        write_reg(CFG_NOISE_FLOOR, 24'd32767);
        write_reg(CFG_MAX_STEP, 24'd0);
        for (int i = 0; i < 100; i++) push_random();
        drain();
        write_reg(CFG_GYRO_WEIGHT, 24'd131071);
        write_reg(CFG_NOISE_FLOOR, 24'd500);
        write_reg(CFG_MAG_LOW, 24'd2000);
        write_reg(CFG_MAG_HIGH, 24'd16000);
        write_reg(CFG_MAX_STEP, 24'd15000);
        // Long receiver hold-off while the sender keeps offering
        for (int i = 0; i < 20; i++) push_random();
        fork
            begin
                hold_rx = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
            end
        join_none
        for (int i = 0; i < 600; i++) push_random();
        while (sample_queue.size() > 0) @(posedge i_clk);
        // Sender pause until every result has come
        hold_sender = 1'b1;
        while (expected_att.size() > 0) @(posedge i_clk);
        hold_sender = 1'b0;
        write_reg(CFG_GYRO_WEIGHT, 24'd50000);
        write_reg(CFG_MAG_LOW, 24'd98304);
        for (int i = 0; i < 100; i++) push_random();
        drain();
        write_reg(CFG_MAG_LOW, 24'd4000);
        write_reg(CFG_MAG_HIGH, 24'd20000);
        write_reg(CFG_GYRO_WEIGHT, 24'd64225);
        for (int i = 0; i < 450; i++) push_random();
        while (sample_queue.size() > 200) @(posedge i_clk);
        calm = 1'b1;
        for (int i = 0; i < 250; i++) push_random();
        drain();

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Timeout
    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

### sim.f
rtl/icf_pkg.sv
rtl/icf_intf.sv
rtl/icf_integ.sv
rtl/icf_cordic.sv
rtl/icf_blend.sv
rtl/imu_complementary_filter_top.sv
tb/tb_pkg.sv
tb/tb_channels.sv
tb/tb.sv
